FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_HOLDS(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(name, clk, rstn, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

FILE: hw/rtl/gec_pkg.sv
// Golomb encoder package: widths, reset constants and the divisor config type.
// No dependencies.
package gec_pkg;

    localparam int SYMBOL_BITS_DEFAULT = 4;
    localparam int QUEUE_DEPTH_DEFAULT = 2;
    localparam int DIV_W               = 8;
    localparam int B_W                 = 4;
    localparam int CODE_W              = 16;
    localparam int LEN_W               = 5;

    typedef struct packed {
        logic [DIV_W-1:0] m_val;
        logic [B_W-1:0]   b_len;
        logic [DIV_W-1:0] u_off;
    } gec_cfg_t;

    // divisor 4: b = 2, u = 0
    localparam gec_cfg_t CFG_RESET = '{m_val: 8'd4, b_len: 4'd2, u_off: 8'd0};

endpackage

FILE: hw/rtl/gec_fifo.sv
// Golomb encoder: small beat queue between front and back.
// Depends on nothing but its parameters.
module gec_fifo #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty,
    output logic             full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: hw/rtl/gec_front.sv
// Golomb encoder front: divisor register with derived b and u, input handshake.
// Depends on gec_pkg.
module gec_front import gec_pkg::*; #(
    parameter int SYMBOL_BITS = SYMBOL_BITS_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [SYMBOL_BITS-1:0] symbol_value,
    input  logic                   cfg_we,
    input  logic [DIV_W-1:0]       cfg_wdata,
    input  logic                   q_full,
    output logic                   busy,
    output logic                   push,
    output logic [SYMBOL_BITS-1:0] push_data,
    output gec_cfg_t               cfg
);

    localparam int DW1 = DIV_W + 1;

    gec_cfg_t         cfg_reg, cfg_next;
    logic [DIV_W-1:0] m_w;
    logic [B_W-1:0]   b_w;

    assign busy      = q_full;
    assign push      = start && !q_full;
    assign push_data = symbol_value;
    assign cfg       = cfg_reg;

    // zero divisor acts as one; b = ceil(log2 m), u = 2^b - m
    always_comb
    begin
        m_w = (cfg_wdata == '0) ? DIV_W'(1) : cfg_wdata;
        b_w = B_W'(DIV_W);
        for (int k = DIV_W; k >= 0; k--)
        begin
            if ((DW1'(1) << k) >= {1'b0, m_w})
            begin
                b_w = B_W'(k);
            end
        end
        cfg_next       = cfg_reg;
        if (cfg_we)
        begin
            cfg_next.m_val = m_w;
            cfg_next.b_len = b_w;
            cfg_next.u_off = DIV_W'((DW1'(1) << b_w) - {1'b0, m_w});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: hw/rtl/gec_back.sv
// Golomb encoder back: pipelined restoring divider, one quotient bit per stage,
// then codeword assembly into the output register. Depends on gec_pkg.
module gec_back import gec_pkg::*; #(
    parameter int SYMBOL_BITS = SYMBOL_BITS_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_empty,
    input  logic [SYMBOL_BITS-1:0] pop_data,
    input  gec_cfg_t               cfg,
    output logic                   pop,
    output logic                   done,
    output logic [CODE_W-1:0]      code_bits,
    output logic [LEN_W-1:0]       code_length
);

    localparam int S   = SYMBOL_BITS;
    localparam int L_W = 10;

    logic             vld_reg [0:S];
    logic [DIV_W-1:0] rem_reg [0:S];
    logic [S-1:0]     quo_reg [0:S];
    logic [S-1:0]     sym_reg [0:S];
    logic [DIV_W:0]   trial   [0:S-1];
    logic             ge      [0:S-1];

    logic              done_reg;
    logic [CODE_W-1:0] code_bits_reg, code_bits_next;
    logic [LEN_W-1:0]  code_length_reg, code_length_next;

    assign pop         = !q_empty;
    assign done        = done_reg;
    assign code_bits   = code_bits_reg;
    assign code_length = code_length_reg;

    always_comb
    begin
        for (int s = 0; s < S; s++)
        begin
            trial[s] = {rem_reg[s], sym_reg[s][S-1-s]};
            ge[s]    = (trial[s] >= {1'b0, cfg.m_val});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= S; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= pop;
            for (int s = 0; s < S; s++)
            begin
                vld_reg[s+1] <= vld_reg[s];
            end
            done_reg <= vld_reg[S];
        end
    end

    // stage s sets only quotient bit S-1-s, which is still zero on entry
    always_ff @(posedge clk)
    begin
        rem_reg[0] <= '0;
        quo_reg[0] <= '0;
        sym_reg[0] <= pop_data;
        for (int s = 0; s < S; s++)
        begin
            rem_reg[s+1] <= ge[s] ? DIV_W'(trial[s] - {1'b0, cfg.m_val})
                                  : trial[s][DIV_W-1:0];
            quo_reg[s+1] <= quo_reg[s] | (S'(ge[s]) << (S - 1 - s));
            sym_reg[s+1] <= sym_reg[s];
        end
        code_bits_reg   <= code_bits_next;
        code_length_reg <= code_length_next;
    end

    // unary quotient, a zero, then truncated-binary remainder; keep first 16 bits
    logic             lt;
    logic [B_W-1:0]   n_len;
    logic [DIV_W-1:0] fld;
    logic [L_W-1:0]   q_ext;
    logic [L_W-1:0]   full_len;
    logic [L_W-1:0]   len_c;
    logic [L_W-1:0]   j_pos;
    logic [L_W-1:0]   f_idx;

    always_comb
    begin
        q_ext    = L_W'(quo_reg[S]);
        lt       = (rem_reg[S] < cfg.u_off);
        n_len    = lt ? (cfg.b_len - 1'b1) : cfg.b_len;
        fld      = lt ? rem_reg[S] : DIV_W'(rem_reg[S] + cfg.u_off);
        full_len = q_ext + L_W'(1) + L_W'(n_len);
        len_c    = (full_len > L_W'(CODE_W)) ? L_W'(CODE_W) : full_len;
        code_length_next = LEN_W'(len_c);
        code_bits_next   = '0;
        j_pos            = '0;
        f_idx            = '0;
        for (int p = 0; p < CODE_W; p++)
        begin
            j_pos = len_c - L_W'(1) - L_W'(p);
            f_idx = L_W'(n_len) + q_ext - j_pos;
            if (L_W'(p) < len_c)
            begin
                if (j_pos < q_ext)
                begin
                    code_bits_next[p] = 1'b1;
                end
                else if (j_pos == q_ext)
                begin
                    code_bits_next[p] = 1'b0;
                end
                else
                begin
                    code_bits_next[p] = fld[f_idx[2:0]];
                end
            end
        end
    end

endmodule

FILE: hw/rtl/golomb_encoder_core.sv
// Golomb encoder: one beat in per cycle, one codeword beat out per input.
// From the accepting edge to the edge taking the result, a beat passes the queue
// slot, the divider input register, SYMBOL_BITS divider stages, assembly register.
// Throughput one beat per cycle, set by the fully pipelined divider; busy rises
// only if the queue fills. Reset clears the valid bits and queue; divisor resets to 4.
// Depends on gec_pkg, gec_front, gec_fifo, gec_back.
module golomb_encoder_core import gec_pkg::*; #(
    parameter int SYMBOL_BITS = SYMBOL_BITS_DEFAULT,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [SYMBOL_BITS-1:0] symbol_value,
    input  logic                   cfg_we,
    input  logic [DIV_W-1:0]       cfg_wdata,
    output logic                   done,
    output logic [CODE_W-1:0]      code_bits,
    output logic [LEN_W-1:0]       code_length
);

    gec_cfg_t               cfg;
    logic                   push;
    logic [SYMBOL_BITS-1:0] push_data;
    logic                   pop;
    logic [SYMBOL_BITS-1:0] pop_data;
    logic                   q_empty;
    logic                   q_full;

    gec_front #(
        .SYMBOL_BITS (SYMBOL_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .symbol_value (symbol_value),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .q_full       (q_full),
        .busy         (busy),
        .push         (push),
        .push_data    (push_data),
        .cfg          (cfg)
    );

    gec_fifo #(
        .WIDTH (SYMBOL_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (q_empty),
        .full      (q_full)
    );

    gec_back #(
        .SYMBOL_BITS (SYMBOL_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .pop_data    (pop_data),
        .cfg         (cfg),
        .pop         (pop),
        .done        (done),
        .code_bits   (code_bits),
        .code_length (code_length)
    );

endmodule

FILE: hw/rtl/gec_checker.sv
// Golomb encoder port checker and its bind to the top level.
// Depends on gec_pkg and assert_macros.svh.
`include "assert_macros.svh"

module gec_checker import gec_pkg::*; #(
    parameter int SYMBOL_BITS = SYMBOL_BITS_DEFAULT
) (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input logic [CODE_W-1:0] code_bits,
    input logic [LEN_W-1:0]  code_length
);

    localparam int LATENCY = SYMBOL_BITS + 3;

    `ASSERT_HOLDS(a_len_range, clk, rst_n, done |-> (code_length != '0 && code_length <= LEN_W'(CODE_W)), "code_length out of range")
    `ASSERT_HOLDS(a_high_zero, clk, rst_n, done |-> ((code_bits >> code_length) == '0), "bits set above code_length")
    `ASSERT_HOLDS(a_beat_out, clk, rst_n, (start && !busy) |-> ##LATENCY done, "accepted beat gave no result")
    `ASSERT_NEVER(a_no_extra, clk, rst_n, done && !$past(start && !busy, LATENCY), "result without accepted beat")

endmodule

bind golomb_encoder_core gec_checker #(
    .SYMBOL_BITS (SYMBOL_BITS)
) u_gec_checker (.*);
